// File: rtl/rakps_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the range value store
// no dependencies
package rakps_pkg;

  localparam int unsigned POSITIONS_DEF = 64;
  localparam int unsigned DW            = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ASSIGN = 2'd1,
    CMD_KTH    = 2'd2,
    CMD_POWSUM = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_ASG,
    ST_KI_RD,
    ST_KI_WT,
    ST_KJ_RD,
    ST_KJ_CMP,
    ST_KI_CHK,
    ST_PS_RD,
    ST_PS_WT,
    ST_PS_EXP,
    ST_PS_SQR,
    ST_PS_ACC,
    ST_MM,
    ST_DONE
  } state_e;

  typedef enum logic {
    DST_BASE,
    DST_POW
  } mm_dst_e;

endpackage

// File: rtl/rakps_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module rakps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/range_assign_add_kth_powsum_store_top.sv
`timescale 1ns / 1ps
// Range value store: one 32-bit value per position, commands act on [left, right).
// Handles one transaction at a time. After reset a clearing pass zeroes the store
// before the first transaction is taken. Per position of the range: assign writes the
// value and add reads then writes the sum. k-th smallest tries each candidate in turn
// and compares it with every position of the range. Power sum reduces each value and
// raises it by square and multiply with a bit-serial modular multiplier that does
// one multiplier bit per cycle. An empty range or a bad rank finishes with an error
// without touching the store. A finished result waits in its own output register, so
// the next transaction can be taken while it is stalled. Depends on rakps_pkg and
// rakps_ram.
module range_assign_add_kth_powsum_store_top
  import rakps_pkg::*;
#(
  parameter int unsigned POSITIONS = POSITIONS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    command_i,
  input  logic [5:0]    left_i,
  input  logic [6:0]    right_i,
  input  logic [DW-1:0] value_i,
  input  logic [5:0]    rank_index_i,
  input  logic [DW-1:0] exponent_i,
  input  logic [DW-1:0] modulus_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [DW-1:0] answer_o,
  output logic          error_o
);

  localparam int unsigned AW  = $clog2(POSITIONS);
  localparam int unsigned LW  = (AW + 1 > 7) ? AW + 1 : 7;
  localparam int unsigned CNW = $clog2(DW + 1);

  state_e          state_q, state_d, ret_q, ret_d;
  mm_dst_e         dst_q, dst_d;
  cmd_e            cmd_q, cmd_d;
  logic [LW-1:0]   i_q, i_d, j_q, j_d, hi_q, hi_d;
  logic [LW-1:0]   lo_q, lo_d, rank_q, rank_d;
  logic [LW-1:0]   less_q, less_d, leq_q, leq_d;
  logic [DW-1:0]   val_q, val_d, exp_q, exp_d, vi_q, vi_d;
  logic [DW-1:0]   ex0_q, ex0_d;
  logic [DW:0]     m_q, m_d, b_q, b_d, pw_q, pw_d, tot_q, tot_d;
  logic [DW:0]     acc_q, acc_d, y_q, y_d;
  logic [DW-1:0]   x_q, x_d;
  logic [CNW-1:0]  cnt_q, cnt_d;
  logic [DW-1:0]   ans_q, ans_d;
  logic            err_q, err_d, ov_q, ov_d;
  logic [DW-1:0]   res_ans_q, res_ans_d;
  logic            res_err_q, res_err_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [DW-1:0]   wdata, rdata;

  logic [LW-1:0]   r_ext, hi_sat, lo_ext, rk_ext;
  logic [DW:0]     m_in, one;
  logic [DW+1:0]   t, s;
  logic            last;

  rakps_ram #(
    .WIDTH(DW),
    .DEPTH(POSITIONS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      i_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q  <= ret_d;   dst_q  <= dst_d;   cmd_q  <= cmd_d;
    j_q    <= j_d;     hi_q   <= hi_d;    lo_q   <= lo_d;
    rank_q <= rank_d;  less_q <= less_d;  leq_q  <= leq_d;
    val_q  <= val_d;   exp_q  <= exp_d;   vi_q   <= vi_d;
    m_q    <= m_d;     b_q    <= b_d;     pw_q   <= pw_d;
    tot_q  <= tot_d;   acc_q  <= acc_d;   y_q    <= y_d;
    x_q    <= x_d;     cnt_q  <= cnt_d;   ans_q  <= ans_d;
    err_q  <= err_d;   ex0_q  <= ex0_d;
    res_ans_q <= res_ans_d;
    res_err_q <= res_err_d;
  end

  always_comb begin
    r_ext  = LW'(right_i);
    hi_sat = (r_ext > LW'(POSITIONS)) ? LW'(POSITIONS) : r_ext;
    lo_ext = LW'(left_i);
    rk_ext = LW'(rank_index_i);
    m_in   = (modulus_i == '0) ? {1'b1, {DW{1'b0}}} : {1'b0, modulus_i};
    one    = (m_q == (DW+1)'(1)) ? '0 : (DW+1)'(1);
    last   = (i_q == hi_q - LW'(1));

    // one bit of the shift-add modular multiplier
    t = {acc_q, 1'b0};
    if (t >= {1'b0, m_q}) t = t - {1'b0, m_q};
    if (x_q[DW-1]) t = t + {1'b0, y_q};
    if (t >= {1'b0, m_q}) t = t - {1'b0, m_q};

    s = {1'b0, tot_q} + {1'b0, pw_q};
    if (s >= {1'b0, m_q}) s = s - {1'b0, m_q};

    state_d = state_q; ret_d = ret_q; dst_d = dst_q; cmd_d = cmd_q;
    i_d = i_q; j_d = j_q; hi_d = hi_q; lo_d = lo_q; rank_d = rank_q;
    less_d = less_q; leq_d = leq_q; val_d = val_q; exp_d = exp_q;
    vi_d = vi_q; m_d = m_q; b_d = b_q; pw_d = pw_q; tot_d = tot_q;
    acc_d = acc_q; y_d = y_q; x_d = x_q; cnt_d = cnt_q;
    ans_d = ans_q; err_d = err_q; ex0_d = ex0_q;
    res_ans_d = res_ans_q; res_err_d = res_err_q;
    ov_d  = ov_q & ~out_ready_i;
    we = 1'b0; waddr = i_q[AW-1:0]; wdata = val_q; raddr = i_q[AW-1:0];
    in_ready_o = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        if (i_q == LW'(POSITIONS - 1)) state_d = ST_IDLE;
        i_d = i_q + LW'(1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d  = cmd_e'(command_i);
          lo_d   = lo_ext;
          hi_d   = hi_sat;
          rank_d = rk_ext;
          val_d  = value_i;
          exp_d  = exponent_i;
          ex0_d  = exponent_i;
          m_d    = m_in;
          i_d    = lo_ext;
          tot_d  = '0;
          ans_d  = '0;
          err_d  = 1'b0;
          if (lo_ext >= hi_sat) begin
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            case (cmd_e'(command_i))
              CMD_ADD:    state_d = ST_ADD_RD;
              CMD_ASSIGN: state_d = ST_ASG;
              CMD_KTH: begin
                if (rk_ext >= hi_sat - lo_ext) begin
                  err_d   = 1'b1;
                  state_d = ST_DONE;
                end else begin
                  state_d = ST_KI_RD;
                end
              end
              default:    state_d = ST_PS_RD;
            endcase
          end
        end
      end
      ST_ADD_RD: state_d = ST_ADD_WR;
      ST_ADD_WR: begin
        we    = 1'b1;
        wdata = rdata + val_q;
        i_d   = i_q + LW'(1);
        state_d = last ? ST_DONE : ST_ADD_RD;
      end
      ST_ASG: begin
        we  = 1'b1;
        i_d = i_q + LW'(1);
        if (last) state_d = ST_DONE;
      end
      ST_KI_RD: state_d = ST_KI_WT;
      ST_KI_WT: begin
        vi_d    = rdata;
        j_d     = lo_q;
        less_d  = '0;
        leq_d   = '0;
        state_d = ST_KJ_RD;
      end
      ST_KJ_RD: begin
        raddr   = j_q[AW-1:0];
        state_d = ST_KJ_CMP;
      end
      ST_KJ_CMP: begin
        if (rdata < vi_q)  less_d = less_q + LW'(1);
        if (rdata <= vi_q) leq_d  = leq_q + LW'(1);
        j_d     = j_q + LW'(1);
        state_d = (j_q == hi_q - LW'(1)) ? ST_KI_CHK : ST_KJ_RD;
      end
      ST_KI_CHK: begin
        if (less_q <= rank_q && rank_q < leq_q) begin
          ans_d   = vi_q;
          state_d = ST_DONE;
        end else begin
          i_d     = i_q + LW'(1);
          state_d = ST_KI_RD;
        end
      end
      ST_PS_RD: state_d = ST_PS_WT;
      ST_PS_WT: begin
        // reduce the stored value: value * 1 mod m
        x_d = rdata; y_d = one; acc_d = '0; cnt_d = CNW'(DW);
        dst_d = DST_BASE; ret_d = ST_PS_EXP;
        // the exponent is reloaded from the transaction for each position
        pw_d = one; exp_d = ex0_q;
        state_d = ST_MM;
      end
      ST_PS_EXP: begin
        if (exp_q == '0) begin
          state_d = ST_PS_ACC;
        end else if (exp_q[0]) begin
          x_d = pw_q[DW-1:0]; y_d = b_q; acc_d = '0; cnt_d = CNW'(DW);
          dst_d = DST_POW; ret_d = ST_PS_SQR;
          state_d = ST_MM;
        end else begin
          state_d = ST_PS_SQR;
        end
      end
      ST_PS_SQR: begin
        exp_d = exp_q >> 1;
        if (exp_q[DW-1:1] == '0) begin
          state_d = ST_PS_EXP;
        end else begin
          x_d = b_q[DW-1:0]; y_d = b_q; acc_d = '0; cnt_d = CNW'(DW);
          dst_d = DST_BASE; ret_d = ST_PS_EXP;
          state_d = ST_MM;
        end
      end
      ST_PS_ACC: begin
        tot_d = s[DW:0];
        i_d   = i_q + LW'(1);
        if (last) begin
          ans_d   = s[DW-1:0];
          state_d = ST_DONE;
        end else begin
          state_d = ST_PS_RD;
        end
      end
      ST_MM: begin
        acc_d = t[DW:0];
        x_d   = x_q << 1;
        cnt_d = cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          if (dst_q == DST_BASE) b_d = t[DW:0];
          else                   pw_d = t[DW:0];
          state_d = ret_q;
        end
      end
      ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d      = 1'b1;
          res_ans_d = ans_q;
          res_err_d = err_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign answer_o    = res_ans_q;
  assign error_o     = res_err_q;

endmodule

// File: rtl/rakps_chk.sv
`timescale 1ns / 1ps
// port-level checks for the range value store, bound to the top level
// depends on rakps_pkg
module rakps_chk
  import rakps_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input logic [DW-1:0] answer_o,
  input logic          error_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(answer_o) && $stable(error_o))
    else $error("result changed while stalled");

  // failed commands report a zero answer
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> answer_o == '0)
    else $error("error result with non-zero answer");

  // one transaction at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting a transaction");

endmodule

bind range_assign_add_kth_powsum_store_top rakps_chk u_rakps_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .answer_o   (answer_o),
  .error_o    (error_o)
);
